// File: rtl/ssas_pkg.sv
package ssas_pkg;

  localparam int FRAC_BITS = 16;
  // width of the projected dot product after the fixed-point shift
  localparam int DN_W = 51 - FRAC_BITS;
  localparam int NDN_W = 18 + DN_W;
  // quotient bits below the saturation limit
  localparam int DIV_STEPS = 31;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W = 2;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;

  localparam logic [2:0] REG_START_X  = 3'd0;
  localparam logic [2:0] REG_START_Y  = 3'd1;
  localparam logic [2:0] REG_END_X    = 3'd2;
  localparam logic [2:0] REG_END_Y    = 3'd3;
  localparam logic [2:0] REG_NORMAL_X = 3'd4;
  localparam logic [2:0] REG_NORMAL_Y = 3'd5;

  localparam logic REQ_SIDE  = 1'b0;
  localparam logic REQ_SLIDE = 1'b1;

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
  } cfg_t;

  typedef struct packed {
    logic               req;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [32:0] qx;
    logic signed [32:0] qy;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
  } item_t;

  typedef struct packed {
    logic               req;
    logic               right;
    logic               par;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } cargo_t;

  typedef struct packed {
    logic               side_right;
    logic signed [31:0] slide_x;
    logic signed [31:0] slide_y;
    logic               blocked;
    logic               parallel;
  } res_t;

  function automatic logic signed [31:0] sat(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'(SAT_MAX)) begin
      r = SAT_MAX;
    end else if (v < -64'(SAT_MAX)) begin
      r = -SAT_MAX;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/ssas_front.sv
module ssas_front (
  input  ssas_pkg::cfg_t      cfg,
  input  logic                req_valid,
  input  logic                req_type,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  dir_x,
  input  logic signed [31:0]  dir_y,
  input  logic                full,
  output logic                req_stall,
  output logic                push,
  output ssas_pkg::item_t     item
);

  assign req_stall = full;
  assign push      = req_valid && !full;

  // offsets between position and segment start: qx/qy serve side requests, rx/ry slide requests
  always_comb begin
    item.req = req_type;
    item.px  = pos_x;
    item.py  = pos_y;
    item.dx  = dir_x;
    item.dy  = dir_y;
    item.qx  = 33'(pos_x) - 33'(cfg.sx);
    item.qy  = 33'(pos_y) - 33'(cfg.sy);
    item.rx  = ssas_pkg::sat(64'(cfg.sx) - 64'(pos_x));
    item.ry  = ssas_pkg::sat(64'(cfg.sy) - 64'(pos_y));
  end

endmodule

// File: rtl/ssas_fifo.sv
module ssas_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ssas_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output ssas_pkg::item_t pop_item,
  output logic            empty
);

  ssas_pkg::item_t                 mem [0:ssas_pkg::FIFO_DEPTH-1];
  logic [ssas_pkg::PTR_W-1:0]      wp;
  logic [ssas_pkg::PTR_W-1:0]      rp;
  logic [ssas_pkg::PTR_W:0]        cnt;

  assign full     = cnt == (ssas_pkg::PTR_W+1)'(ssas_pkg::FIFO_DEPTH);
  assign empty    = cnt == '0;
  assign pop_item = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_item;
    end
  end

endmodule

// File: rtl/ssas_div.sv
module ssas_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [63:0] num,
  input  logic signed [63:0] den,
  input  ssas_pkg::cargo_t   in_cargo,
  output logic               out_valid,
  output logic signed [31:0] quot,
  output ssas_pkg::cargo_t   out_cargo
);

  localparam int N = ssas_pkg::DIV_STEPS;
  localparam int F = ssas_pkg::FRAC_BITS;

  // magnitude stage
  logic             v0;
  logic             neg0;
  logic [63:0]      un0;
  logic [63:0]      ud0;
  ssas_pkg::cargo_t cg0;

  logic [63:0] un_c;
  logic [63:0] ud_c;
  assign un_c = num[63] ? ~num + 64'd1 : num;
  assign ud_c = den[63] ? ~den + 64'd1 : den;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg0 <= num[63] ^ den[63];
      un0  <= un_c;
      ud0  <= ud_c;
      cg0  <= in_cargo;
    end
  end

  // scaled numerator; its top part against the divisor decides saturation
  logic [63+F:0] nfull;
  logic [32+F:0] top;
  assign nfull = {un0, {F{1'b0}}};
  assign top   = nfull[63+F:31];

  logic             vs   [0:N];
  logic             negs [0:N];
  logic             sats [0:N];
  logic [63:0]      rs   [0:N];
  logic [63:0]      uds  [0:N];
  logic [N-1:0]     qs   [0:N];
  logic [N-1:0]     nls  [0:N];
  ssas_pkg::cargo_t cgs  [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else if (en) begin
      vs[0] <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      negs[0] <= neg0;
      sats[0] <= 64'(top) >= ud0;
      rs[0]   <= 64'(top);
      uds[0]  <= ud0;
      qs[0]   <= '0;
      nls[0]  <= nfull[N-1:0];
      cgs[0]  <= cg0;
    end
  end

  // one restoring step per stage
  for (genvar j = 0; j < N; j++) begin : g_step
    logic [63:0] rr;
    logic        ge;
    assign rr = {rs[j][62:0], nls[j][N-1-j]};
    assign ge = rr >= uds[j];

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[j+1] <= 1'b0;
      end else if (en) begin
        vs[j+1] <= vs[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        negs[j+1] <= negs[j];
        sats[j+1] <= sats[j];
        rs[j+1]   <= ge ? rr - uds[j] : rr;
        uds[j+1]  <= uds[j];
        qs[j+1]   <= {qs[j][N-2:0], ge};
        nls[j+1]  <= nls[j];
        cgs[j+1]  <= cgs[j];
      end
    end
  end

  logic signed [31:0] qv;
  assign qv = sats[N] ? ssas_pkg::SAT_MAX : $signed({1'b0, qs[N]});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vs[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quot      <= negs[N] ? -qv : qv;
      out_cargo <= cgs[N];
    end
  end

endmodule

// File: rtl/ssas_back.sv
module ssas_back (
  input  logic             clk,
  input  logic             rst,
  input  ssas_pkg::cfg_t   cfg,
  input  logic             empty,
  input  ssas_pkg::item_t  item,
  output logic             pop,
  input  logic             res_stall,
  output logic             res_valid,
  output ssas_pkg::res_t   res
);

  localparam int F = ssas_pkg::FRAC_BITS;
  localparam int DW = ssas_pkg::DN_W;
  localparam int NW = ssas_pkg::NDN_W;

  logic adv;
  assign adv = !res_valid || !res_stall;
  assign pop = adv && !empty;

  logic signed [31:0] wx;
  logic signed [31:0] wy;
  assign wx = ssas_pkg::sat(64'(cfg.ex) - 64'(cfg.sx));
  assign wy = ssas_pkg::sat(64'(cfg.ey) - 64'(cfg.sy));

  // stage 1: products
  logic               v1, req1;
  logic signed [31:0] px1, py1, dx1, dy1;
  logic signed [50:0] sqx1, sqy1;
  logic signed [49:0] dnx1, dny1;
  logic signed [63:0] cra1, crb1, nua1, nub1;

  // stage 2: sums
  logic               v2, req2, right2;
  logic signed [31:0] px2, py2, dx2, dy2;
  logic signed [DW-1:0] dn2;
  logic signed [63:0] c2, num2;

  // stage 3: normal times dot product
  logic               v3, req3, right3;
  logic signed [31:0] px3, py3, dx3, dy3;
  logic signed [NW-1:0] ndx3, ndy3;
  logic signed [63:0] c3, num3;

  // stage 4: projected slide
  logic               v4;
  ssas_pkg::cargo_t   cg4;
  logic signed [63:0] c4, num4;

  // divider output
  logic               dv;
  logic signed [31:0] t;
  ssas_pkg::cargo_t   cgd;

  // stages 5 to 8: meet point, offsets, squares
  logic               v5, v6, v7, v8;
  ssas_pkg::cargo_t   cg5, cg6, cg7, cg8;
  logic signed [63:0] tdx5, tdy5;
  logic signed [31:0] mx6, my6;
  logic signed [31:0] eox7, eoy7, sox7, soy7;
  logic signed [63:0] twa8, twb8, vva8, vvb8, eea8, eeb8, ssa8, ssb8;

  logic signed [51:0] dside;
  logic signed [50:0] dsum;
  logic signed [50:0] dsh;
  assign dside = 52'(sqx1) + 52'(sqy1);
  assign dsum  = 51'(dnx1) + 51'(dny1);
  assign dsh   = dsum >>> F;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else if (adv) begin
      v1 <= pop;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= dv;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      req1 <= item.req;
      px1  <= item.px;
      py1  <= item.py;
      dx1  <= item.dx;
      dy1  <= item.dy;
      sqx1 <= 51'(item.qx) * 51'(cfg.nx);
      sqy1 <= 51'(item.qy) * 51'(cfg.ny);
      dnx1 <= 50'(item.dx) * 50'(cfg.nx);
      dny1 <= 50'(item.dy) * 50'(cfg.ny);
      cra1 <= 64'(item.dx) * 64'(wy);
      crb1 <= 64'(item.dy) * 64'(wx);
      nua1 <= 64'(item.rx) * 64'(wy);
      nub1 <= 64'(item.ry) * 64'(wx);

      req2   <= req1;
      right2 <= dside[51];
      px2    <= px1;
      py2    <= py1;
      dx2    <= dx1;
      dy2    <= dy1;
      dn2    <= dsh[DW-1:0];
      c2     <= cra1 - crb1;
      num2   <= nua1 - nub1;

      req3   <= req2;
      right3 <= right2;
      px3    <= px2;
      py3    <= py2;
      dx3    <= dx2;
      dy3    <= dy2;
      ndx3   <= NW'(cfg.nx) * NW'(dn2);
      ndy3   <= NW'(cfg.ny) * NW'(dn2);
      c3     <= c2;
      num3   <= num2;

      cg4.req   <= req3;
      cg4.right <= right3;
      cg4.par   <= c3 == 64'sd0;
      cg4.px    <= px3;
      cg4.py    <= py3;
      cg4.dx    <= dx3;
      cg4.dy    <= dy3;
      cg4.vx    <= ssas_pkg::sat(64'(dx3) - 64'(ndx3 >>> F));
      cg4.vy    <= ssas_pkg::sat(64'(dy3) - 64'(ndy3 >>> F));
      c4        <= c3;
      num4      <= num3;

      cg5  <= cgd;
      tdx5 <= 64'(t) * 64'(cgd.dx);
      tdy5 <= 64'(t) * 64'(cgd.dy);

      cg6 <= cg5;
      mx6 <= ssas_pkg::sat(64'(cg5.px) + (tdx5 >>> F));
      my6 <= ssas_pkg::sat(64'(cg5.py) + (tdy5 >>> F));

      cg7  <= cg6;
      eox7 <= ssas_pkg::sat(64'(cfg.ex) - 64'(mx6));
      eoy7 <= ssas_pkg::sat(64'(cfg.ey) - 64'(my6));
      sox7 <= ssas_pkg::sat(64'(cfg.sx) - 64'(mx6));
      soy7 <= ssas_pkg::sat(64'(cfg.sy) - 64'(my6));

      cg8  <= cg7;
      twa8 <= 64'(cg7.vx) * 64'(eox7);
      twb8 <= 64'(cg7.vy) * 64'(eoy7);
      vva8 <= 64'(cg7.vx) * 64'(cg7.vx);
      vvb8 <= 64'(cg7.vy) * 64'(cg7.vy);
      eea8 <= 64'(eox7) * 64'(eox7);
      eeb8 <= 64'(eoy7) * 64'(eoy7);
      ssa8 <= 64'(sox7) * 64'(sox7);
      ssb8 <= 64'(soy7) * 64'(soy7);
    end
  end

  ssas_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v4),
    .num       (num4),
    .den       (c4),
    .in_cargo  (cg4),
    .out_valid (dv),
    .quot      (t),
    .out_cargo (cgd)
  );

  // stage 9: length compare and result
  logic signed [63:0] toward, vlen, lim;
  logic               fits;
  ssas_pkg::res_t     res_next;

  always_comb begin
    toward = twa8 + twb8;
    vlen   = vva8 + vvb8;
    lim    = (toward >= 64'sd0) ? eea8 + eeb8 : ssa8 + ssb8;
    fits   = vlen < lim;
    res_next = '0;
    if (cg8.req == ssas_pkg::REQ_SIDE) begin
      res_next.side_right = cg8.right;
    end else if (cg8.par) begin
      res_next.slide_x  = cg8.vx;
      res_next.slide_y  = cg8.vy;
      res_next.parallel = 1'b1;
    end else if (fits) begin
      res_next.slide_x = cg8.vx;
      res_next.slide_y = cg8.vy;
    end else begin
      res_next.blocked = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= res_next;
    end
  end

endmodule

// File: rtl/segment_side_and_slide.sv
// throughput: one beat per cycle while res_stall is low, set by the fully pipelined
//   31-step divider and the single-stall pipeline behind the four-entry request queue
// reset: rst is synchronous, active high; clears the queue, pipeline valids
//   and all six segment registers to zero
module segment_side_and_slide (
  input  logic               clk,
  input  logic               rst,

  // apb configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,

  // request channel
  input  logic               req_valid,
  output logic               req_stall,
  input  logic               req_type,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,

  // result channel
  output logic               res_valid,
  input  logic               res_stall,
  output logic               side_right,
  output logic signed [31:0] slide_x,
  output logic signed [31:0] slide_y,
  output logic               blocked,
  output logic               parallel
);

  // segment registers; the user must write them only while no request is in flight, not enforced here
  ssas_pkg::cfg_t cfg;
  logic           wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (paddr[4:2])
        ssas_pkg::REG_START_X:  cfg.sx <= pwdata;
        ssas_pkg::REG_START_Y:  cfg.sy <= pwdata;
        ssas_pkg::REG_END_X:    cfg.ex <= pwdata;
        ssas_pkg::REG_END_Y:    cfg.ey <= pwdata;
        ssas_pkg::REG_NORMAL_X: cfg.nx <= pwdata[17:0];
        ssas_pkg::REG_NORMAL_Y: cfg.ny <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  // readback, normals sign extended
  always_comb begin
    case (paddr[4:2])
      ssas_pkg::REG_START_X:  prdata = cfg.sx;
      ssas_pkg::REG_START_Y:  prdata = cfg.sy;
      ssas_pkg::REG_END_X:    prdata = cfg.ex;
      ssas_pkg::REG_END_Y:    prdata = cfg.ey;
      ssas_pkg::REG_NORMAL_X: prdata = 32'(cfg.nx);
      ssas_pkg::REG_NORMAL_Y: prdata = 32'(cfg.ny);
      default:                prdata = '0;
    endcase
  end

  // front: takes a beat whenever the queue has room
  logic            push;
  logic            full;
  logic            empty;
  logic            pop;
  ssas_pkg::item_t in_item;
  ssas_pkg::item_t q_item;
  ssas_pkg::res_t  res;

  ssas_front u_front (
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_type  (req_type),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .dir_x     (dir_x),
    .dir_y     (dir_y),
    .full      (full),
    .req_stall (req_stall),
    .push      (push),
    .item      (in_item)
  );

  // queue decouples the front from stalls at the result side
  ssas_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (in_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (q_item),
    .empty     (empty)
  );

  // back: products, meet-point divide, length compare; the whole pipe
  // holds together while the result register is stalled
  ssas_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .empty     (empty),
    .item      (q_item),
    .pop       (pop),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .res       (res)
  );

  assign side_right = res.side_right;
  assign slide_x    = res.slide_x;
  assign slide_y    = res.slide_y;
  assign blocked    = res.blocked;
  assign parallel   = res.parallel;

`ifndef ASSERT_OFF
  a_blocked_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && blocked |-> slide_x == 32'sd0 && slide_y == 32'sd0 && !parallel && !side_right)
    else $error("blocked result carries a slide");

  a_side_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && side_right |-> !blocked && !parallel && slide_x == 32'sd0)
    else $error("side result mixed with slide fields");

  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid && !req_stall)
    else $error("result or stall active after reset");
`endif

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

  // one request beat as the sender offers it
  typedef struct {
    logic               kind;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
  } query_t;

  localparam longint CLAMP = 64'sd2147483647;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic               req_type = ssas_pkg::REQ_SIDE;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;
  logic signed [31:0] dir_x = '0;
  logic signed [31:0] dir_y = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  logic               side_right;
  logic signed [31:0] slide_x;
  logic signed [31:0] slide_y;
  logic               blocked;
  logic               parallel;

  segment_side_and_slide uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
    .pos_x(pos_x), .pos_y(pos_y), .dir_x(dir_x), .dir_y(dir_y),
    .res_valid(res_valid), .res_stall(res_stall), .side_right(side_right),
    .slide_x(slide_x), .slide_y(slide_y), .blocked(blocked), .parallel(parallel)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the wall registers
  logic signed [31:0] wall_sx, wall_sy, wall_ex, wall_ey;
  logic signed [17:0] wall_nx, wall_ny;

  query_t         pending_queries[$];
  ssas_pkg::res_t awaited_answers[$];

  logic req_taken = 1'b0;
  int   send_gap = 0;
  int   hold_cnt = 0;
  bit   calm = 1'b0;
  bit   long_hold_req = 1'b0;
  int   errors = 0;
  int   n_side = 0, n_slide = 0, n_par = 0, n_blocked = 0, n_results = 0;

  function automatic longint clamp32(longint v);
    if (v > CLAMP) return CLAMP;
    if (v < -CLAMP) return -CLAMP;
    return v;
  endfunction

  // num * 2^16 / den, truncated toward zero, clamped
  function automatic longint meet_param(longint num, longint den);
    logic [127:0] un, ud, q;
    longint       an, ad;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    un = 128'(an);
    ud = 128'(ad);
    q = (un << ssas_pkg::FRAC_BITS) / ud;
    if (q > 128'(CLAMP)) q = 128'(CLAMP);
    return ((num < 0) != (den < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  // expected answer of the wall for one query
  function automatic ssas_pkg::res_t wall_answer(query_t q);
    ssas_pkg::res_t r;
    longint sx, sy, ex, ey, nx, ny, px, py, dx, dy;
    longint dn, vx, vy, wx, wy, c, rx, ry, t, mx, my, eox, eoy, sox, soy;
    longint toward, vlen, lim;
    sx = wall_sx; sy = wall_sy; ex = wall_ex; ey = wall_ey;
    nx = wall_nx; ny = wall_ny;
    px = q.px; py = q.py; dx = q.dx; dy = q.dy;
    r = '0;
    if (q.kind == ssas_pkg::REQ_SIDE) begin
      r.side_right = ((px - sx) * nx + (py - sy) * ny) < 0;
    end else begin
      // projection onto the wall, products floored
      dn = (dx * nx + dy * ny) >>> ssas_pkg::FRAC_BITS;
      vx = clamp32(dx - ((nx * dn) >>> ssas_pkg::FRAC_BITS));
      vy = clamp32(dy - ((ny * dn) >>> ssas_pkg::FRAC_BITS));
      wx = clamp32(ex - sx);
      wy = clamp32(ey - sy);
      c = dx * wy - dy * wx;
      if (c == 0) begin
        // no meet point, slide passes through
        r.parallel = 1'b1;
        r.slide_x = vx[31:0];
        r.slide_y = vy[31:0];
      end else begin
        rx = clamp32(sx - px);
        ry = clamp32(sy - py);
        t = meet_param(rx * wy - ry * wx, c);
        mx = clamp32(px + ((t * dx) >>> ssas_pkg::FRAC_BITS));
        my = clamp32(py + ((t * dy) >>> ssas_pkg::FRAC_BITS));
        eox = clamp32(ex - mx); eoy = clamp32(ey - my);
        sox = clamp32(sx - mx); soy = clamp32(sy - my);
        toward = vx * eox + vy * eoy;
        vlen = vx * vx + vy * vy;
        lim = (toward >= 0) ? eox * eox + eoy * eoy : sox * sox + soy * soy;
        if (vlen < lim) begin
          r.slide_x = vx[31:0];
          r.slide_y = vy[31:0];
        end else begin
          r.blocked = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // accept side: predict at the accepting edge
  always @(posedge clk) begin
    query_t q;
    req_taken <= req_valid && !req_stall;
    if (!rst && req_valid && !req_stall) begin
      q.kind = req_type; q.px = pos_x; q.py = pos_y; q.dx = dir_x; q.dy = dir_y;
      awaited_answers.push_back(wall_answer(q));
      if (req_type == ssas_pkg::REQ_SIDE) n_side++; else n_slide++;
    end
  end

  // result monitor
  always @(posedge clk) begin
    ssas_pkg::res_t want;
    if (!rst && res_valid && !res_stall) begin
      n_results++;
      if (awaited_answers.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing awaited", $time);
      end else begin
        want = awaited_answers.pop_front();
        if (parallel) n_par++;
        if (blocked) n_blocked++;
        if (want.side_right !== side_right || want.slide_x !== slide_x ||
            want.slide_y !== slide_y || want.blocked !== blocked ||
            want.parallel !== parallel) begin
          errors++;
          $display("%0t: expected r=%b x=%0d y=%0d b=%b p=%b, actual r=%b x=%0d y=%0d b=%b p=%b",
                   $time, want.side_right, want.slide_x, want.slide_y, want.blocked,
                   want.parallel, side_right, slide_x, slide_y, blocked, parallel);
        end
      end
    end
  end

  // request driver, fed from the pending queue
  always @(negedge clk) begin
    query_t q;
    if (req_valid && !req_taken) begin
      // stalled beat stays put
    end else if (send_gap > 0) begin
      req_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_queries.size() > 0) begin
      q = pending_queries.pop_front();
      req_valid <= 1'b1;
      req_type <= q.kind;
      pos_x <= q.px; pos_y <= q.py; dir_x <= q.dx; dir_y <= q.dy;
      if (!calm && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 8);
    end else begin
      req_valid <= 1'b0;
    end
  end

  // result receiver: random stall bursts, one long hold on request
  always @(negedge clk) begin
    if (long_hold_req && hold_cnt == 0) begin
      long_hold_req <= 1'b0;
      hold_cnt <= 300;
      res_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      res_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      hold_cnt <= $urandom_range(0, 7);
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      ssas_pkg::REG_START_X:  wall_sx = val;
      ssas_pkg::REG_START_Y:  wall_sy = val;
      ssas_pkg::REG_END_X:    wall_ex = val;
      ssas_pkg::REG_END_Y:    wall_ey = val;
      ssas_pkg::REG_NORMAL_X: wall_nx = val[17:0];
      ssas_pkg::REG_NORMAL_Y: wall_ny = val[17:0];
      default: ;
    endcase
  endtask

  task automatic set_wall(input logic [31:0] sx, sy, ex, ey, input logic [17:0] nx, ny);
    write_reg(ssas_pkg::REG_START_X, sx);
    write_reg(ssas_pkg::REG_START_Y, sy);
    write_reg(ssas_pkg::REG_END_X, ex);
    write_reg(ssas_pkg::REG_END_Y, ey);
    write_reg(ssas_pkg::REG_NORMAL_X, {{14{nx[17]}}, nx});
    write_reg(ssas_pkg::REG_NORMAL_Y, {{14{ny[17]}}, ny});
  endtask

  task automatic add_query(input logic k, input logic [31:0] px, py, dx, dy);
    query_t q;
    q.kind = k; q.px = px; q.py = py; q.dx = dx; q.dy = dy;
    pending_queries.push_back(q);
  endtask

  // sender stops until every awaited answer is back, then lets the pipe drain
  task automatic drain_all();
    wait (pending_queries.size() == 0 && !req_valid);
    wait (awaited_answers.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_span(int bits);
    logic [31:0] v;
    v = $urandom;
    if (bits < 32) v = $signed(v[31:0] << (32 - bits)) >>> (32 - bits);
    return v;
  endfunction

  function automatic logic [17:0] rand_normal();
    case ($urandom_range(0, 4))
      0: return 18'sd65536;
      1: return -18'sd65536;
      2: return 18'd0;
      default: return 18'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  // mostly well-scaled queries near the wall, some parallel, some full range
  task automatic add_random(input int count);
    logic [31:0] dx, dy;
    logic        k;
    repeat (count) begin
      k = $urandom_range(0, 1);
      case ($urandom_range(0, 9))
        0: add_query(k, $urandom, $urandom, $urandom, $urandom);
        1: begin
          dx = $signed(wall_ex - wall_sx) >>> $urandom_range(0, 12);
          dy = $signed(wall_ey - wall_sy) >>> $urandom_range(0, 12);
          if ($urandom_range(0, 1)) begin dx = -dx; dy = -dy; end
          add_query(k, rand_span(24), rand_span(24), dx, dy);
        end
        2: add_query(k, rand_span(22), rand_span(22), '0, '0);
        default: add_query(k, rand_span(23), rand_span(23), rand_span(20), rand_span(20));
      endcase
    end
  endtask

  initial begin
    wall_sx = '0; wall_sy = '0; wall_ex = '0; wall_ey = '0; wall_nx = '0; wall_ny = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset wall: everything zero, every slide is parallel
    add_query(ssas_pkg::REQ_SIDE, 32'h0001_0000, 32'hffff_0000, '0, '0);
    add_query(ssas_pkg::REQ_SLIDE, 32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 32'h0001_0000);
    drain_all();

    // directed: horizontal wall from origin to x=10, normal +y
    set_wall(32'h0, 32'h0, 32'h000a_0000, 32'h0, 18'd0, 18'sd65536);
    add_query(ssas_pkg::REQ_SIDE, 32'h0005_0000, 32'h0001_0000, '0, '0);      // left
    add_query(ssas_pkg::REQ_SIDE, 32'h0005_0000, 32'hffff_0000, '0, '0);      // right
    add_query(ssas_pkg::REQ_SIDE, 32'h0003_0000, 32'h0, '0, '0);              // on line
    add_query(ssas_pkg::REQ_SIDE, 32'h7fff_ffff, 32'h8000_0000, '1, '1);
    add_query(ssas_pkg::REQ_SIDE, 32'h8000_0000, 32'h7fff_ffff, '0, '0);
    add_query(ssas_pkg::REQ_SLIDE, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'hffff_0000);
    add_query(ssas_pkg::REQ_SLIDE, 32'h0008_0000, 32'h0001_0000, 32'h0004_0000, 32'hffff_0000);
    add_query(ssas_pkg::REQ_SLIDE, 32'h0008_0000, 32'h0001_0000, 32'hfff0_0000, 32'hffff_0000);
    // parallel
    add_query(ssas_pkg::REQ_SLIDE, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'h0);
    // zero motion
    add_query(ssas_pkg::REQ_SLIDE, 32'h0002_0000, 32'h0001_0000, 32'h0, 32'h0);
    // meets at end
    add_query(ssas_pkg::REQ_SLIDE, 32'h000a_0000, 32'h0001_0000, 32'h0, 32'hffff_0000);
    // meets at start
    add_query(ssas_pkg::REQ_SLIDE, 32'h0, 32'h0001_0000, 32'h0, 32'hffff_0000);
    // zero slide
    add_query(ssas_pkg::REQ_SLIDE, 32'h0002_0000, 32'h0001_0000, 32'h0, 32'hffff_0000);
    add_query(ssas_pkg::REQ_SLIDE, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    add_query(ssas_pkg::REQ_SLIDE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    // huge t
    add_query(ssas_pkg::REQ_SLIDE, 32'h0001_0000, 32'h0000_0001, 32'h0, 32'hffff_ffff);
    add_query(ssas_pkg::REQ_SLIDE, '1, '1, 32'h0000_0001, 32'h7fff_ffff);
    drain_all();

    // extreme corner-to-corner wall; receiver holds off long while sender keeps offering
    set_wall(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
             -18'sd65536, 18'sd65536);
    long_hold_req = 1'b1;
    add_random(120);
    drain_all();

    // vertical wall
    set_wall(32'h0003_0000, 32'hfffb_0000, 32'h0003_0000, 32'h0005_0000,
             -18'sd65536, 18'd0);
    add_random(150);
    drain_all();

    // random walls with random normals
    repeat (3) begin
      set_wall(rand_span(24), rand_span(24), rand_span(24), rand_span(24),
               rand_normal(), rand_normal());
      add_random(70);
      drain_all();
    end

    // full-range wall, no idling on either side
    set_wall($urandom, $urandom, $urandom, $urandom, 18'sd65536, -18'sd65536);
    calm = 1'b1;
    add_random(120);
    drain_all();

    $display("covered %0d side and %0d slide beats over 8 wall settings", n_side, n_slide);
    $display("%0d results: %0d parallel, %0d blocked", n_results, n_par, n_blocked);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d answers awaited", awaited_answers.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: filelist.f
rtl/ssas_pkg.sv
rtl/ssas_front.sv
rtl/ssas_fifo.sv
rtl/ssas_div.sv
rtl/ssas_back.sv
rtl/segment_side_and_slide.sv
verif/testbench.sv
